/* rtl/core/sis_pkg.sv */
// Shared types and codes for the sortable id stack.
// Request and status codes, beat payload structs. No dependencies.
`default_nettype none

package sis_pkg;

  localparam int unsigned IdW = 31;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_SORT = 2'd2,
    REQ_DUMP = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]     req_type;
    logic [IdW-1:0] push_id;
  } req_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [IdW-1:0] entry_id;
    logic           last;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/sortable_id_stack.sv */
// Sortable id stack: LIFO of 31-bit ids with push, pop, in-place sort, dump.
// Top level: sequencer; instantiates sis_ram and sis_outreg; uses sis_pkg.
//
// A bounded LIFO of STACK_DEPTH ids kept in one synchronous RAM (slot 0 is
// the bottom). Requests arrive as beats on the in channel, results leave as
// beats on the out channel, each request giving one result beat except a
// dump of a non-empty stack, which gives one beat per entry, top first; the
// last beat of every request has last set. Push on a full stack returns
// status full and drops the id; pop or dump on an empty stack returns status
// empty. Sort orders the entries ascending from top to bottom with one
// bubble pass per entry but one, each streaming through the RAM. Push and
// every request answered at once may run back to back while the sink
// keeps up; pop passes through a pop state for the RAM read, dump alternates
// emit and read states, and sort runs load, first, step and tail states per
// pass, owing to the single read port of the RAM and its registered read.
// A request is taken only while the sequencer is idle and the output
// register can accept a beat; the output register holds a finished beat
// while the sequencer goes on. The RAM needs no clearing after reset: only
// slots below the entry count are ever used.
`default_nettype none

module sortable_id_stack #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire sis_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output sis_pkg::res_t      out_data_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IW = sis_pkg::IdW;

  // sequencer states
  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_POP        = 4'd1;
  localparam logic [3:0] S_DUMP_EMIT  = 4'd2;
  localparam logic [3:0] S_DUMP_RD    = 4'd3;
  localparam logic [3:0] S_SORT_LOAD  = 4'd4;
  localparam logic [3:0] S_SORT_FIRST = 4'd5;
  localparam logic [3:0] S_SORT_STEP  = 4'd6;
  localparam logic [3:0] S_SORT_TAIL  = 4'd7;
  localparam logic [3:0] S_SORT_ACK   = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;    // dump slot / sort walk slot
  logic [AW-1:0] pass_q, pass_d;  // sort pass
  logic [IW-1:0] carry_q, carry_d; // value bubbling upward

  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] top_addr;
  logic          is_empty, is_full, accept, can_load;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [IW-1:0] ram_wdata, ram_rdata;

  logic          res_load;
  sis_pkg::res_t res;

  assign cnt_m1   = cnt_q - CW'(1);
  assign top_addr = cnt_m1[AW-1:0];
  assign is_empty = (cnt_q == '0);
  assign is_full  = (cnt_q == CW'(STACK_DEPTH));

  assign in_ready_o = (state_q == S_IDLE) && can_load;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    pass_d    = pass_q;
    carry_d   = carry_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = top_addr;   // keeps the top slot on the read data when idle
    res_load  = 1'b0;
    res       = '0;
    res.last  = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data_i.req_type)
            sis_pkg::REQ_PUSH: begin
              res_load = 1'b1;
              if (is_full) begin
                res.status = sis_pkg::ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = cnt_q[AW-1:0];
                ram_wdata  = in_data_i.push_id;
                cnt_d      = cnt_q + CW'(1);
                res.status = sis_pkg::ST_OK;
              end
            end
            sis_pkg::REQ_POP: begin
              if (is_empty) begin
                res_load   = 1'b1;
                res.status = sis_pkg::ST_EMPTY;
              end else begin
                state_d = S_POP;
              end
            end
            sis_pkg::REQ_SORT: begin
              if (cnt_q < CW'(2)) begin
                res_load   = 1'b1;
                res.status = sis_pkg::ST_OK;
              end else begin
                pass_d  = '0;
                state_d = S_SORT_LOAD;
              end
            end
            sis_pkg::REQ_DUMP: begin
              if (is_empty) begin
                res_load   = 1'b1;
                res.status = sis_pkg::ST_EMPTY;
              end else begin
                // top slot was read at the accept edge
                idx_d   = top_addr;
                state_d = S_DUMP_EMIT;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_POP: begin
        if (can_load) begin
          res_load     = 1'b1;
          res.status   = sis_pkg::ST_OK;
          res.entry_id = ram_rdata;
          cnt_d        = cnt_m1;
          state_d      = S_IDLE;
        end
      end

      S_DUMP_EMIT: begin
        ram_raddr = idx_q;
        if (can_load) begin
          res_load     = 1'b1;
          res.status   = sis_pkg::ST_OK;
          res.entry_id = ram_rdata;
          res.last     = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q - AW'(1);
            state_d = S_DUMP_RD;
          end
        end
      end

      S_DUMP_RD: begin
        ram_raddr = idx_q;
        state_d   = S_DUMP_EMIT;
      end

      S_SORT_LOAD: begin
        ram_raddr = '0;
        state_d   = S_SORT_FIRST;
      end

      S_SORT_FIRST: begin
        carry_d   = ram_rdata;
        ram_raddr = AW'(1);
        idx_d     = AW'(1);
        state_d   = S_SORT_STEP;
      end

      S_SORT_STEP: begin
        // larger id sinks to slot idx-1, smaller one travels on
        ram_we    = 1'b1;
        ram_waddr = idx_q - AW'(1);
        if (ram_rdata > carry_q) begin
          ram_wdata = ram_rdata;
        end else begin
          ram_wdata = carry_q;
          carry_d   = ram_rdata;
        end
        if (idx_q == top_addr) begin
          state_d = S_SORT_TAIL;
        end else begin
          ram_raddr = idx_q + AW'(1);
          idx_d     = idx_q + AW'(1);
        end
      end

      S_SORT_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = top_addr;
        ram_wdata = carry_q;
        if (pass_q == top_addr - AW'(1)) begin
          state_d = S_SORT_ACK;
        end else begin
          pass_d  = pass_q + AW'(1);
          state_d = S_SORT_LOAD;
        end
      end

      S_SORT_ACK: begin
        if (can_load) begin
          res_load   = 1'b1;
          res.status = sis_pkg::ST_OK;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    pass_q  <= pass_d;
    carry_q <= carry_d;
  end

  sis_ram #(
    .Width (IW),
    .Depth (STACK_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sis_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .data_i      (res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* rtl/core/sis_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sis_ram #(
  parameter int unsigned Width = 31,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/sis_outreg.sv */
// Result output register: holds one beat until the sink takes it.
// Depends on sis_pkg for the result struct.
`default_nettype none

module sis_outreg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire sis_pkg::res_t data_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output sis_pkg::res_t      out_data_o
);

  logic          valid_q, valid_d;
  sis_pkg::res_t data_q;

  // free now, or the held beat leaves at this edge
  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire
